@@ hdl/itad_pkg.sv @@
package itad_pkg;

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned DIGITS   = 20;
	localparam int unsigned BCD_W    = 4 * DIGITS;
	localparam int unsigned HEX_NIBS = 16;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned ITER_W   = 4;

	localparam logic [1:0] CMD_UNSIGNED = 2'd0;
	localparam logic [1:0] CMD_SIGNED   = 2'd1;
	localparam logic [1:0] CMD_HEX      = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic convert;
		logic trim;
		logic emit;
		logic sign_sel;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;
		logic iter_last;
		logic top_zero;
		logic cnt_one;
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_CONVERT = 5'b00010,
		ST_TRIM    = 5'b00100,
		ST_SIGN    = 5'b01000,
		ST_EMIT    = 5'b10000
	} state_t;

endpackage

@@ hdl/itad_dp.sv @@
module itad_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  itad_pkg::ctrl_t           ctrl,
	input  logic [1:0]                command,
	input  logic [itad_pkg::VALUE_W-1:0] value,
	output itad_pkg::stat_t           stat,
	output logic [7:0]                character
);

	localparam int unsigned WORD_W = itad_pkg::BCD_W + itad_pkg::VALUE_W;

	logic [itad_pkg::VALUE_W-1:0] bin_q;
	logic [itad_pkg::BCD_W-1:0]   bcd_q;
	logic [itad_pkg::CNT_W-1:0]   cnt_q;
	logic [itad_pkg::ITER_W-1:0]  iter_q;
	logic                         hex_q;
	logic                         neg_q;
	logic                         neg_in;
	logic [WORD_W-1:0]            dab_word;
	logic [3:0]                   out_nib;

	// Four shift-and-correct steps of the double-dabble conversion.
	function automatic logic [WORD_W-1:0] dabble4(input logic [WORD_W-1:0] w_in);
		logic [WORD_W-1:0] w;
		w = w_in;
		for (int b = 0; b < 4; b++) begin
			for (int d = 0; d < itad_pkg::DIGITS; d++) begin
				if (w[itad_pkg::VALUE_W + 4*d +: 4] >= 4'd5) begin
					w[itad_pkg::VALUE_W + 4*d +: 4] = w[itad_pkg::VALUE_W + 4*d +: 4] + 4'd3;
				end
			end
			w = {w[WORD_W-2:0], 1'b0};
		end
		return w;
	endfunction

	assign neg_in   = (command == itad_pkg::CMD_SIGNED) && value[itad_pkg::VALUE_W-1];
	assign dab_word = dabble4({bcd_q, bin_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			iter_q <= '0;
			hex_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else if (ctrl.load) begin
			hex_q  <= command[1];
			neg_q  <= neg_in;
			iter_q <= '0;
			cnt_q  <= itad_pkg::CNT_W'(itad_pkg::HEX_NIBS);
		end else if (ctrl.convert) begin
			iter_q <= iter_q + 1'b1;
			if (&iter_q) begin
				cnt_q <= itad_pkg::CNT_W'(itad_pkg::DIGITS);
			end
		end else if (ctrl.trim || ctrl.emit) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= neg_in ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (ctrl.convert) begin
			{bcd_q, bin_q} <= dab_word;
		end else if (ctrl.trim) begin
			bcd_q <= {bcd_q[itad_pkg::BCD_W-5:0], 4'd0};
		end else if (ctrl.emit) begin
			if (hex_q) begin
				bin_q <= {bin_q[itad_pkg::VALUE_W-5:0], 4'd0};
			end else begin
				bcd_q <= {bcd_q[itad_pkg::BCD_W-5:0], 4'd0};
			end
		end
	end

	assign out_nib = hex_q ? bin_q[itad_pkg::VALUE_W-1 -: 4] : bcd_q[itad_pkg::BCD_W-1 -: 4];

	always_comb begin
		if (ctrl.sign_sel) begin
			character = itad_pkg::CHAR_MINUS;
		end else if (out_nib > 4'd9) begin
			character = {4'd0, out_nib} + itad_pkg::HEX_ALPHA_OFS;
		end else begin
			character = {4'd0, out_nib} + itad_pkg::CHAR_ZERO;
		end
	end

	assign stat.neg       = neg_q;
	assign stat.iter_last = &iter_q;
	assign stat.top_zero  = (bcd_q[itad_pkg::BCD_W-1 -: 4] == 4'd0);
	assign stat.cnt_one   = (cnt_q == itad_pkg::CNT_W'(1));

endmodule

@@ hdl/itad_ctrl.sv @@
module itad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [1:0]      command,
	input  logic            out_ready,
	input  itad_pkg::stat_t stat,
	output itad_pkg::ctrl_t ctrl,
	output logic            in_ready,
	output logic            out_valid,
	output logic            out_last
);

	itad_pkg::state_t state_q;
	itad_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		out_last      = 1'b0;
		case (state_q)
			itad_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					ctrl.load = 1'b1;
					state_d   = command[1] ? itad_pkg::ST_EMIT : itad_pkg::ST_CONVERT;
				end
			end
			itad_pkg::ST_CONVERT: begin
				ctrl.convert = 1'b1;
				if (stat.iter_last) begin
					state_d = itad_pkg::ST_TRIM;
				end
			end
			itad_pkg::ST_TRIM: begin
				// Drop leading zero digits but always keep the last one.
				if (stat.top_zero && !stat.cnt_one) begin
					ctrl.trim = 1'b1;
				end else begin
					state_d = stat.neg ? itad_pkg::ST_SIGN : itad_pkg::ST_EMIT;
				end
			end
			itad_pkg::ST_SIGN: begin
				ctrl.sign_sel = 1'b1;
				out_valid     = 1'b1;
				if (out_ready) begin
					state_d = itad_pkg::ST_EMIT;
				end
			end
			itad_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				out_last  = stat.cnt_one;
				if (out_ready) begin
					ctrl.emit = 1'b1;
					if (stat.cnt_one) begin
						state_d = itad_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itad_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/integer_to_ascii_digits_unit.sv @@
// Converts a 64-bit value to ASCII text, one character per output transaction.
// Hex: the first character follows in the cycle after the input transaction; 16 characters per value.
// Decimal: double dabble (4 bits per step) and then trimming of leading zero digits come before the
// first character; then one character per cycle while m_tready is high, with a minus sign first if negative.
// One value is converted at a time; s_tready is high only while the unit is idle.
// arst_n clears the controller asynchronously; the unit then waits idle for a value.
module integer_to_ascii_digits_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] character
	output logic        m_tlast
);

	itad_pkg::ctrl_t ctrl;
	itad_pkg::stat_t stat;
	logic            in_fire;

	assign in_fire = s_tvalid && s_tready;

	itad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.command   (s_tuser),
		.out_ready (m_tready),
		.stat      (stat),
		.ctrl      (ctrl),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast)
	);

	itad_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.command   (s_tuser),
		.value     (s_tdata),
		.stat      (stat),
		.character (m_tdata)
	);

endmodule
